@@ rtl/srtpl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types for the sorted region table page lookup block.
// No dependencies; used by srtpl_cell and sorted_region_table_page_lookup.
package srtpl_pkg;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_INS_END   = 6'b000010,
    ST_INS_SHIFT = 6'b000100,
    ST_SEARCH    = 6'b001000,
    ST_HIT       = 6'b010000,
    ST_RESULT    = 6'b100000
  } state_e;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef struct packed {
    logic ins_en;   // insert shift cycle
    logic valid;    // slot is below the region count
    logic prev_le;  // left neighbor start <= key
    logic first;    // slot 0, no left neighbor
  } cell_ctrl_t;

endpackage

@@ rtl/srtpl_cell.sv @@
`timescale 1ns / 1ps
// One region slot of the sorted table: holds start and end, compares against
// the key and on insert takes its left neighbor or the new region. Depends on srtpl_pkg.
module srtpl_cell #(
  parameter int unsigned AW = 48
) (
  input  logic                  clk_i,
  input  srtpl_pkg::cell_ctrl_t ctrl_i,
  input  logic [AW-1:0]         key_i,
  input  logic [AW-1:0]         new_end_i,
  input  logic [AW-1:0]         prev_start_i,
  input  logic [AW-1:0]         prev_end_i,
  output logic [AW-1:0]         start_o,
  output logic [AW-1:0]         end_o,
  output logic                  le_o,
  output logic                  here_o
);

  logic [AW-1:0] start_q, start_d;
  logic [AW-1:0] end_q, end_d;

  assign le_o   = ctrl_i.valid && (start_q <= key_i);
  assign here_o = !le_o && (ctrl_i.first || ctrl_i.prev_le);

  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    if (ctrl_i.ins_en && !le_o) begin
      if (here_o) begin
        start_d = key_i;
        end_d   = new_end_i;
      end else begin
        start_d = prev_start_i;
        end_d   = prev_end_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
  end

  assign start_o = start_q;
  assign end_o   = end_q;

endmodule

@@ rtl/sorted_region_table_page_lookup.sv @@
`timescale 1ns / 1ps
// Sorted region table with page lookup: a chain of region cells kept sorted
// by start, binary search for lookups. Depends on srtpl_pkg and srtpl_cell.
//
// Input channel (in_valid_i / in_stall_o) carries one beat per operation:
// operation 0 looks up address_i, operation 1 inserts the region
// [address_i, address_i + length_i). Every input beat yields exactly one
// output beat on (out_valid_o / out_stall_i).
// Insert: end saturation, then a shift step in which every cell past the
// insertion slot takes its left neighbor and the slot cell takes the new
// region, then result transfer. A full table goes straight to the result.
// Lookup: binary search of at most clog2(MAX_REGIONS) + 1 steps (5 for 16
// regions), then result transfer; each step reads one slot
// through the cell select mux and compares against start and end.
// One item is in work at a time; the next beat is taken as soon as the
// previous result moves into the output register, even while the receiver
// stalls it. A stalled output beat holds until taken.
// Reset empties the table (region count to zero) and drops any pending beat.
module sorted_region_table_page_lookup #(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned PAGE_BITS   = 12,
  parameter int unsigned ADDR_BITS   = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [47:0] address_i,
  input  logic [47:0] length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [47:0] page_base_o,
  output logic [3:0]  region_index_o,
  output logic [35:0] page_in_region_o,
  output logic        table_full_o
);

  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam logic [AW-1:0] PG_MASK = {AW{1'b1}} << PAGE_BITS;

  srtpl_pkg::state_e state_q, state_d;

  logic          op_q, op_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [47:0]   len_q, len_d;
  logic [AW-1:0] end_q, end_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] left_q, left_d;
  logic [CW-1:0] right_q, right_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] diff_q, diff_d;
  logic [AW-1:0] hstart_q, hstart_d;
  logic [IW-1:0] hidx_q, hidx_d;

  logic          res_hit_q, res_hit_d;
  logic [47:0]   res_base_q, res_base_d;
  logic [3:0]    res_idx_q, res_idx_d;
  logic [35:0]   res_page_q, res_page_d;
  logic          res_full_q, res_full_d;

  logic          out_valid_q, out_valid_d;
  logic          out_hit_q;
  logic [47:0]   out_base_q;
  logic [3:0]    out_idx_q;
  logic [35:0]   out_page_q;
  logic          out_full_q;

  logic [AW-1:0] cell_start [MAX_REGIONS];
  logic [AW-1:0] cell_end   [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] cell_le;
  logic [MAX_REGIONS-1:0] cell_here;
  logic          ins_en;

  logic          in_beat;
  logic          out_free;
  logic [63:0]   addr_ext;
  logic [64:0]   sum_ext;
  logic [AW-1:0] sat_end;
  logic [AW-1:0] rd_start, rd_end;
  logic          srch_live, is_lt, is_ge;
  logic [CW:0]   mid_lt, mid_ge;
  logic [IW-1:0] ins_pos;
  logic [AW-1:0] page_aw, base_aw;
  logic [63:0]   page_ext, base_ext, hidx_ext, pos_ext;

  assign in_stall_o = (state_q != srtpl_pkg::ST_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // region cells
  for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
    srtpl_pkg::cell_ctrl_t ctrl;
    logic prev_le, head;
    logic [AW-1:0] prev_start, prev_end;
    if (g == 0) begin : g_first
      assign prev_le    = 1'b0;
      assign head       = 1'b1;
      assign prev_start = addr_q;
      assign prev_end   = end_q;
    end else begin : g_rest
      assign prev_le    = cell_le[g-1];
      assign head       = 1'b0;
      assign prev_start = cell_start[g-1];
      assign prev_end   = cell_end[g-1];
    end
    assign ctrl = '{ins_en: ins_en, valid: (CW'(g) < count_q), prev_le: prev_le,
                    first: head};

    srtpl_cell #(.AW(AW)) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .key_i       (addr_q),
      .new_end_i   (end_q),
      .prev_start_i(prev_start),
      .prev_end_i  (prev_end),
      .start_o     (cell_start[g]),
      .end_o       (cell_end[g]),
      .le_o        (cell_le[g]),
      .here_o      (cell_here[g])
    );
  end

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      if (cell_here[i]) begin
        ins_pos = ins_pos | IW'(i);
      end
    end
  end

  assign addr_ext = 64'(address_i);
  assign sum_ext  = 65'(addr_q) + 65'(len_q);
  assign sat_end  = (|(sum_ext >> AW)) ? {AW{1'b1}} : sum_ext[AW-1:0];

  assign rd_start  = cell_start[idx_q[IW-1:0]];
  assign rd_end    = cell_end[idx_q[IW-1:0]];
  assign srch_live = right_q > left_q;
  assign is_lt     = addr_q < rd_start;
  assign is_ge     = addr_q >= rd_end;
  // next midpoint for the lower and the upper half
  assign mid_lt    = (CW+1)'(left_q) + (CW+1)'(idx_q);
  assign mid_ge    = (CW+1)'(idx_q) + (CW+1)'(right_q) + 1'b1;

  assign page_aw  = diff_q >> PAGE_BITS;
  assign base_aw  = hstart_q + (diff_q & PG_MASK);
  assign page_ext = 64'(page_aw);
  assign base_ext = 64'(base_aw);
  assign hidx_ext = 64'(hidx_q);
  assign pos_ext  = 64'(ins_pos);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    addr_d     = addr_q;
    len_d      = len_q;
    end_d      = end_q;
    count_d    = count_q;
    left_d     = left_q;
    right_d    = right_q;
    diff_d     = diff_q;
    hstart_d   = hstart_q;
    hidx_d     = hidx_q;
    res_hit_d  = res_hit_q;
    res_base_d = res_base_q;
    res_idx_d  = res_idx_q;
    res_page_d = res_page_q;
    res_full_d = res_full_q;
    ins_en     = 1'b0;
    idx_d      = idx_q;

    case (state_q)
      srtpl_pkg::ST_IDLE: begin
        if (in_beat) begin
          op_d       = operation_i;
          addr_d     = addr_ext[AW-1:0];
          len_d      = length_i;
          left_d     = '0;
          right_d    = count_q;
          idx_d      = count_q >> 1;
          res_hit_d  = 1'b0;
          res_base_d = '0;
          res_idx_d  = '0;
          res_page_d = '0;
          res_full_d = 1'b0;
          if (operation_i == srtpl_pkg::OP_INSERT) begin
            if (count_q == CW'(MAX_REGIONS)) begin
              res_full_d = 1'b1;
              state_d    = srtpl_pkg::ST_RESULT;
            end else begin
              state_d = srtpl_pkg::ST_INS_END;
            end
          end else begin
            state_d = srtpl_pkg::ST_SEARCH;
          end
        end
      end
      srtpl_pkg::ST_INS_END: begin
        end_d   = sat_end;
        state_d = srtpl_pkg::ST_INS_SHIFT;
      end
      srtpl_pkg::ST_INS_SHIFT: begin
        ins_en    = 1'b1;
        count_d   = count_q + 1'b1;
        res_hit_d = 1'b1;
        res_idx_d = pos_ext[3:0];
        state_d   = srtpl_pkg::ST_RESULT;
      end
      srtpl_pkg::ST_SEARCH: begin
        if (!srch_live) begin
          state_d = srtpl_pkg::ST_RESULT;
        end else if (is_lt) begin
          right_d = idx_q;
          idx_d   = mid_lt[CW:1];
        end else if (is_ge) begin
          left_d = idx_q + 1'b1;
          idx_d  = mid_ge[CW:1];
        end else begin
          diff_d   = addr_q - rd_start;
          hstart_d = rd_start;
          hidx_d   = idx_q[IW-1:0];
          state_d  = srtpl_pkg::ST_HIT;
        end
      end
      srtpl_pkg::ST_HIT: begin
        res_hit_d  = 1'b1;
        res_base_d = base_ext[47:0];
        res_idx_d  = hidx_ext[3:0];
        res_page_d = page_ext[35:0];
        state_d    = srtpl_pkg::ST_RESULT;
      end
      srtpl_pkg::ST_RESULT: begin
        if (out_free) begin
          state_d = srtpl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srtpl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (state_q == srtpl_pkg::ST_RESULT && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srtpl_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    addr_q     <= addr_d;
    len_q      <= len_d;
    end_q      <= end_d;
    left_q     <= left_d;
    right_q    <= right_d;
    idx_q      <= idx_d;
    diff_q     <= diff_d;
    hstart_q   <= hstart_d;
    hidx_q     <= hidx_d;
    res_hit_q  <= res_hit_d;
    res_base_q <= res_base_d;
    res_idx_q  <= res_idx_d;
    res_page_q <= res_page_d;
    res_full_q <= res_full_d;
    if (state_q == srtpl_pkg::ST_RESULT && out_free) begin
      out_hit_q  <= res_hit_q;
      out_base_q <= res_base_q;
      out_idx_q  <= res_idx_q;
      out_page_q <= res_page_q;
      out_full_q <= res_full_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = out_hit_q;
  assign page_base_o      = out_base_q;
  assign region_index_o   = out_idx_q;
  assign page_in_region_o = out_page_q;
  assign table_full_o     = out_full_q;

  // a rejected insert is never also a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && table_full_o))
    else $error("hit and table_full both set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_REGIONS))
    else $error("region count beyond table size");

  // sorted table: exactly one insertion slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == srtpl_pkg::ST_INS_SHIFT |-> $onehot(cell_here))
    else $error("insert slot not unique");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srtpl_pkg::ST_INS_SHIFT) && (op_q == srtpl_pkg::OP_INSERT)
      |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not bump region count");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sorted_region_table_page_lookup: a directed table of
// inserts and lookups, then randomized traffic, checked against a shadow region
// table (typed directed rows carry their own answer). Depends on srtpl_pkg and the block RTL.
module tb_top;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned PG_BITS = 12;
  localparam int DIR_ROWS = 25;
  localparam int RAND_ITEMS = 900;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic        hit;
    logic [47:0] base;
    logic [3:0]  idx;
    logic [35:0] page;
    logic        full;
  } page_result_t;

  typedef struct packed {
    srtpl_pkg::op_e op;
    logic [47:0]    addr;
    logic [47:0]    len;
    logic           typed;
    page_result_t   want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = 1'b0;
  logic [47:0] address_i = '0;
  logic [47:0] length_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        hit_o;
  logic [47:0] page_base_o;
  logic [3:0]  region_index_o;
  logic [35:0] page_in_region_o;
  logic        table_full_o;

  sorted_region_table_page_lookup uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .address_i        (address_i),
    .length_i         (length_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .page_base_o      (page_base_o),
    .region_index_o   (region_index_o),
    .page_in_region_o (page_in_region_o),
    .table_full_o     (table_full_o)
  );

  always #10 clk_i = ~clk_i;

  // directed rows; typed rows carry their answer, the rest use the shadow table
  plan_row_t dir_plan [DIR_ROWS] = '{
    '{srtpl_pkg::OP_LOOKUP, 48'h0000_0000_0000, 48'h0000_0000_0000, 1'b1, '0},
    '{srtpl_pkg::OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, '0},
    '{srtpl_pkg::OP_INSERT, 48'h0000_0010_0000, 48'h0000_0000_4000, 1'b1,
      '{1'b1, 48'h0, 4'd0, 36'd0, 1'b0}},
    '{srtpl_pkg::OP_LOOKUP, 48'h0000_0010_0000, 48'h0, 1'b1,
      '{1'b1, 48'h0000_0010_0000, 4'd0, 36'd0, 1'b0}},
    '{srtpl_pkg::OP_LOOKUP, 48'h0000_0010_3FFF, 48'h0, 1'b1,
      '{1'b1, 48'h0000_0010_3000, 4'd0, 36'd3, 1'b0}},
    '{srtpl_pkg::OP_LOOKUP, 48'h0000_0010_4000, 48'h0, 1'b1, '0},
    '{srtpl_pkg::OP_INSERT, 48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_FFFF, 1'b1,
      '{1'b1, 48'h0, 4'd1, 36'd0, 1'b0}},
    '{srtpl_pkg::OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 48'h5555_5555_5555, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'h0000_0000_0000, 48'h0000_0000_0000, 1'b1,
      '{1'b1, 48'h0, 4'd0, 36'd0, 1'b0}},
    '{srtpl_pkg::OP_LOOKUP, 48'h0000_0000_0000, 48'hAAAA_AAAA_AAAA, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'h0000_0010_0000, 48'h0000_0100_0000, 1'b0, '0},
    '{srtpl_pkg::OP_LOOKUP, 48'h0000_0010_2000, 48'h0, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'h8000_0000_0000, 48'h8000_0000_0000, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'h1234_5678_9ABC, 48'h0000_0001_0000, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'h0000_0000_1000, 48'h0000_0000_1000, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'h7FFF_FFFF_FFFF, 48'h0000_0000_0001, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'h5555_5555_5000, 48'h0000_0010_0000, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'hAAAA_AAAA_A000, 48'h0AAA_AAAA_AAAA, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'h0000_0040_0000, 48'h0000_0000_0FFF, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'h0000_FFFF_0000, 48'h0000_FFFF_0000, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'h0100_0000_0000, 48'h00FF_FFFF_FFFF, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'h0000_0002_0000, 48'h0000_0010_0000, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'h3000_0000_0000, 48'h0000_0000_2000, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'h0000_0010_2000, 48'h0000_0000_3000, 1'b0, '0},
    '{srtpl_pkg::OP_INSERT, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1,
      '{1'b0, 48'h0, 4'd0, 36'd0, 1'b1}}
  };

  logic [47:0]  shadow_start [SLOTS];
  logic [47:0]  shadow_end [SLOTS];
  int unsigned  shadow_count = 0;
  page_result_t answers_due [$];

  int mismatches = 0;
  int results_seen = 0;
  int recv_cycle = 0;
  int stall_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int in_blocked = 0;
  int n_hit = 0;
  int n_miss = 0;
  int n_placed = 0;
  int n_refused = 0;
  page_result_t got;

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  // sorted insert or binary-search lookup on the shadow table
  function automatic page_result_t apply_region_op(srtpl_pkg::op_e op, logic [47:0] a,
                                                   logic [47:0] l);
    page_result_t r;
    int unsigned pos;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [48:0] sum;
    logic [47:0] offs;
    r = '0;
    if (op == srtpl_pkg::OP_INSERT) begin
      if (shadow_count >= SLOTS) begin
        r.full = 1'b1;
        return r;
      end
      pos = 0;
      while (pos < shadow_count && shadow_start[pos] <= a) pos++;
      for (int unsigned i = shadow_count; i > pos; i--) begin
        shadow_start[i] = shadow_start[i - 1];
        shadow_end[i] = shadow_end[i - 1];
      end
      sum = {1'b0, a} + {1'b0, l};
      shadow_start[pos] = a;
      shadow_end[pos] = sum[48] ? '1 : sum[47:0];
      shadow_count++;
      r.hit = 1'b1;
      r.idx = pos[3:0];
      return r;
    end
    lo = 0;
    hi = shadow_count;
    mid = hi / 2;
    while (hi > lo) begin
      if (a < shadow_start[mid]) hi = mid;
      else if (a >= shadow_end[mid]) lo = mid + 1;
      else break;
      mid = (lo + hi) / 2;
    end
    if (lo < hi) begin
      offs = a - shadow_start[mid];
      r.hit = 1'b1;
      r.page = offs[47:PG_BITS];
      r.base = shadow_start[mid] + {offs[47:PG_BITS], {PG_BITS{1'b0}}};
      r.idx = mid[3:0];
    end
    return r;
  endfunction

  task automatic flag_field(input string name, input logic [63:0] want_v,
                            input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s expected %0h got %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // call in the step of a rising edge; returns at the edge that takes the beat
  task automatic offer(input srtpl_pkg::op_e op, input logic [47:0] a,
                       input logic [47:0] l);
    in_valid_i <= 1'b1;
    operation_i <= op;
    address_i <= a;
    length_i <= l;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // result side: check, then pick next stall
  always @(posedge clk_i) begin
    if (in_valid_i && in_stall_o) in_blocked++;
    if (out_valid_o && !out_stall_i) begin
      got = {hit_o, page_base_o, region_index_o, page_in_region_o, table_full_o};
      results_seen++;
      if (answers_due.size() == 0) begin
        $display("%0t ns: result beat with nothing pending, expected none got %h",
                 $time, got);
        mismatches++;
      end else begin
        flag_field("hit", 64'(answers_due[0].hit), 64'(got.hit));
        flag_field("page_base", 64'(answers_due[0].base), 64'(got.base));
        flag_field("region_index", 64'(answers_due[0].idx), 64'(got.idx));
        flag_field("page_in_region", 64'(answers_due[0].page), 64'(got.page));
        flag_field("table_full", 64'(answers_due[0].full), 64'(got.full));
        void'(answers_due.pop_front());
      end
    end
    recv_cycle++;
    if (recv_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 9) < 7);
        default: out_stall_i <= (recv_cycle % 5 < 2);
      endcase
    end
  end

  initial begin
    srtpl_pkg::op_e op;
    logic [47:0]    a;
    logic [47:0]    l;
    logic [47:0]    span;
    page_result_t   r;
    int             kind;
    int             k;
    int             burst_left;
    burst_left = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int n = 0; n < DIR_ROWS + RAND_ITEMS; n++) begin
      if (n < DIR_ROWS) begin
        op = dir_plan[n].op;
        a = dir_plan[n].addr;
        l = dir_plan[n].len;
      end else begin
        kind = $urandom_range(0, 99);
        l = ($urandom_range(0, 1) != 0) ? rand48() : rand48() >> $urandom_range(0, 47);
        k = $urandom_range(0, shadow_count - 1);
        span = shadow_end[k] - shadow_start[k];
        if (kind < 10) begin
          op = srtpl_pkg::OP_INSERT;
          a = rand48();
        end else begin
          op = srtpl_pkg::OP_LOOKUP;
          if (kind < 60 && span != 0) begin
            a = shadow_start[k] + rand48() % span;
          end else if (kind < 75) begin
            case ($urandom_range(0, 3))
              0: a = shadow_start[k];
              1: a = shadow_end[k] - 1;
              2: a = shadow_end[k];
              default: a = shadow_start[k] - 1;
            endcase
          end else begin
            a = rand48() >> $urandom_range(0, 40);
          end
        end
      end
      offer(op, a, l);
      r = apply_region_op(op, a, l);
      if (n < DIR_ROWS && dir_plan[n].typed) r = dir_plan[n].want;
      answers_due.push_back(r);
      if (op == srtpl_pkg::OP_INSERT) begin
        if (r.hit) n_placed++;
        else n_refused++;
      end else begin
        if (r.hit) n_hit++;
        else n_miss++;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 9)) @(posedge clk_i);
        end
      end else begin
        burst_left--;
      end
    end
    in_valid_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d lookups (%0d hits, %0d misses), %0d inserts placed,",
             n_hit + n_miss, n_hit, n_miss, n_placed);
    $display("%0d inserts refused on a full table; input held off for %0d cycles.",
             n_refused, in_blocked);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", answers_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
rtl/srtpl_pkg.sv
rtl/srtpl_cell.sv
rtl/sorted_region_table_page_lookup.sv
tb/tb_top.sv
